@@ hw/rtl/msched_pkg.sv @@
package msched_pkg;

   localparam int TAG_W             = 48;
   localparam int NOW_W             = 40;
   localparam int RATE_W            = 16;
   localparam int STEP_W            = 20;
   localparam int CREDIT_W          = 16;
   localparam int ID_W              = 16;
   localparam int TEN_W             = 3;
   localparam int CNT_W             = 16;
   localparam int PROD_W            = STEP_W + RATE_W;
   localparam int RATE_FRAC         = 12;
   localparam int MAX_ROWS          = 8;
   localparam int TENANTS_DEF       = 8;
   localparam int PENDING_DEPTH_DEF = 16;

   localparam logic [TAG_W-1:0] TAG_MAX      = {TAG_W{1'b1}};
   localparam logic [TAG_W-1:0] ONE_MS       = TAG_W'(256);
   localparam logic [TAG_W-1:0] REBASE_LIMIT = TAG_W'(2);
   localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

   localparam logic [STEP_W-1:0]   RES_STEP_RST = STEP_W'(25600);
   localparam logic [STEP_W-1:0]   LIM_STEP_RST = STEP_W'(12800);
   localparam logic [CREDIT_W-1:0] CREDIT_RST   = CREDIT_W'(3);

   // command codes
   localparam logic [1:0] CMD_ARRIVE   = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_RATES    = 2'd2;
   localparam logic [1:0] CMD_REPORT   = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_REJECT = 3'd1;
   localparam logic [2:0] KIND_DISP   = 3'd2;
   localparam logic [2:0] KIND_NONE   = 3'd3;
   localparam logic [2:0] KIND_RATES  = 3'd4;
   localparam logic [2:0] KIND_REPORT = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_RES_STEP = 2'd0;
   localparam logic [1:0] CSR_LIM_STEP = 2'd1;
   localparam logic [1:0] CSR_CREDIT   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AR_CHK,
      ST_AR_RES,
      ST_AR_LIM,
      ST_RB_MIN,
      ST_RB_SUB,
      ST_AR_SHR,
      ST_DS_SCAN,
      ST_DS_PICK,
      ST_DS_CRED,
      ST_DS_DONE,
      ST_RATE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0] sum_max;
      logic [TAG_W-1:0] diff_floor;
      logic             a_lt_b;
   } tagop_res_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [ID_W-1:0]  request_id;
      logic [TEN_W-1:0] tenant;
      logic             method;
      logic [CNT_W-1:0] reserve_count;
      logic [CNT_W-1:0] weight_count;
      logic             last;
   } rsp_type;

endpackage

@@ hw/rtl/msched_tagop.sv @@
module msched_tagop (
   input  logic [msched_pkg::TAG_W-1:0] op_a,
   input  logic [msched_pkg::TAG_W-1:0] op_b,
   input  logic [msched_pkg::TAG_W-1:0] op_c,
   output msched_pkg::tagop_res_type    res
);
   import msched_pkg::*;

   logic [TAG_W:0]   sum;
   logic [TAG_W-1:0] sat;

   // saturating add, then floor at op_c
   assign sum = {1'b0, op_a} + {1'b0, op_b};
   assign sat = sum[TAG_W] ? TAG_MAX : sum[TAG_W-1:0];
   assign res.sum_max = (sat > op_c) ? sat : op_c;

   // subtract floored at zero, and compare
   assign res.diff_floor = (op_a > op_b) ? (op_a - op_b) : '0;
   assign res.a_lt_b     = (op_a < op_b);

endmodule

@@ hw/rtl/mclock_tag_scheduler_top.sv @@
// Arrival: check, reservation tag, limit tag, share tag; a share rebase adds a minimum scan
// over all tenants, and a subtract pass when a tag is nonzero. Dispatch: slot scan and pick,
// then a credit pass for a weight dispatch (slot scan and credit pass run one slot a cycle).
// Report: one row a cycle while the result side is free. One item in work at a time.
// Reset (synchronous, active high) clears tags, rates, counts, slot valid
// bits and loads the register defaults.
module mclock_tag_scheduler_top #(
   parameter int TENANTS       = msched_pkg::TENANTS_DEF,
   parameter int PENDING_DEPTH = msched_pkg::PENDING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command
   input  logic [1:0]  req_tuser,
   // tenant, request_id, now_ms, rho, delta
   input  logic [95:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind
   output logic [2:0]  rsp_tuser,
   // out_request_id, out_tenant, method, reserve_count, weight_count
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import msched_pkg::*;

   localparam int TW   = (TENANTS > 1) ? $clog2(TENANTS) : 1;
   localparam int SW   = $clog2(PENDING_DEPTH);
   localparam int ROWS = (TENANTS < MAX_ROWS) ? TENANTS : MAX_ROWS;

   localparam logic [TW-1:0] T_LAST = TW'(TENANTS - 1);
   localparam logic [TW-1:0] R_LAST = TW'(ROWS - 1);
   localparam logic [SW-1:0] S_LAST = SW'(PENDING_DEPTH - 1);

   state_type state_ff, state_in;

   logic [STEP_W-1:0]   res_step_ff, lim_step_ff;
   logic [CREDIT_W-1:0] credit_ff;

   // per-tenant state
   logic [TAG_W-1:0]  ten_rtag_ff [TENANTS];
   logic [TAG_W-1:0]  ten_ltag_ff [TENANTS];
   logic [TAG_W-1:0]  ten_stag_ff [TENANTS];
   logic [RATE_W-1:0] ten_rrate_ff [TENANTS];
   logic [RATE_W-1:0] ten_lrate_ff [TENANTS];
   logic [CNT_W-1:0]  res_cnt_ff [TENANTS];
   logic [CNT_W-1:0]  wgt_cnt_ff [TENANTS];

   // pending slots
   logic              slot_valid_ff [PENDING_DEPTH];
   logic [TAG_W-1:0]  slot_rtag_ff [PENDING_DEPTH];
   logic [TAG_W-1:0]  slot_ltag_ff [PENDING_DEPTH];
   logic [TAG_W-1:0]  slot_stag_ff [PENDING_DEPTH];
   logic [TEN_W-1:0]  slot_ten_ff [PENDING_DEPTH];
   logic [ID_W-1:0]   slot_id_ff [PENDING_DEPTH];

   // latched item
   logic [TEN_W-1:0]  ten_ff;
   logic [ID_W-1:0]   id_ff;
   logic [NOW_W-1:0]  now_ff;
   logic [RATE_W-1:0] rho_ff, delta_ff;

   logic [SW-1:0]     sidx_ff, free_ff;
   logic [TW-1:0]     tidx_ff;
   logic [PROD_W-1:0] mul_ff;
   logic [TAG_W-1:0]  mn_ff;
   logic              mn_found_ff;

   logic              rfound_ff, pfound_ff;
   logic [TAG_W-1:0]  rbest_ff, pbest_ff;
   logic [SW-1:0]     rsel_ff, psel_ff;
   logic [TEN_W-1:0]  rsel_ten_ff, psel_ten_ff, pick_ten_ff;
   logic [ID_W-1:0]   rsel_id_ff, psel_id_ff, pick_id_ff;
   logic              method_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    emit, out_free;

   logic [TW-1:0]     t_idx, rd_t;
   logic              t_ok;
   logic [TAG_W-1:0]  now_tag;
   logic [SW-1:0]     free_idx;
   logic              free_any;
   logic              rb_cand;
   logic              r_due;
   logic [TAG_W-1:0]  op_a, op_b, op_c;
   tagop_res_type     tr;

   function automatic logic [31:0] req_ten_ext(input logic [TEN_W-1:0] t);
      req_ten_ext = 32'(t);
   endfunction

   assign t_idx   = TW'(req_ten_ext(ten_ff));
   assign t_ok    = (32'(ten_ff) < TENANTS);
   assign now_tag = {now_ff, 8'b0};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // find lowest free slot
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SW'(i);
            free_any = 1'b1;
         end
      end
   end

   // tenant read address: scan index while rebasing
   assign rd_t = (state_ff == ST_RB_MIN || state_ff == ST_RB_SUB) ? tidx_ff : t_idx;

   // operand select for the shared tag unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      unique case (state_ff)
         ST_AR_RES: begin
            op_a = ten_rtag_ff[rd_t];
            op_b = TAG_W'(mul_ff[PROD_W-1:RATE_FRAC]);
            op_c = now_tag;
         end
         ST_AR_LIM: begin
            op_a = ten_ltag_ff[rd_t];
            op_b = TAG_W'(mul_ff[PROD_W-1:RATE_FRAC]);
            op_c = now_tag;
         end
         ST_RB_MIN: begin
            op_a = ten_stag_ff[rd_t];
            op_b = mn_ff;
         end
         ST_RB_SUB: begin
            op_a = ten_stag_ff[rd_t];
            op_b = {mn_ff[TAG_W-1:8], 8'b0};
         end
         ST_AR_SHR: begin
            op_a = ten_stag_ff[rd_t];
            op_b = ONE_MS;
            op_c = now_tag;
         end
         ST_DS_CRED: begin
            op_a = slot_rtag_ff[sidx_ff];
            op_b = TAG_W'(credit_ff);
         end
         default: ;
      endcase
   end

   msched_tagop u_tagop (
      .op_a (op_a),
      .op_b (op_b),
      .op_c (op_c),
      .res  (tr)
   );

   assign rb_cand = (ten_stag_ff[rd_t] != '0) && (!mn_found_ff || tr.a_lt_b);
   assign r_due   = rfound_ff && (rbest_ff <= now_tag);

   // next state and result
   always_comb begin
      state_in = state_ff;
      emit     = 1'b0;
      rsp_in   = '0;
      rsp_in.last = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  CMD_ARRIVE:   state_in = ST_AR_CHK;
                  CMD_DISPATCH: state_in = ST_DS_SCAN;
                  CMD_RATES:    state_in = ST_RATE;
                  CMD_REPORT:   state_in = ST_REPORT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_AR_CHK: begin
            if (!t_ok || !free_any) begin
               emit = 1'b1;
               rsp_in.kind       = KIND_REJECT;
               rsp_in.request_id = id_ff;
               rsp_in.tenant     = ten_ff;
               if (out_free) state_in = ST_IDLE;
            end else begin
               state_in = ST_AR_RES;
            end
         end
         ST_AR_RES: state_in = ST_AR_LIM;
         ST_AR_LIM: begin
            state_in = (ten_stag_ff[rd_t] <= REBASE_LIMIT) ? ST_RB_MIN : ST_AR_SHR;
         end
         ST_RB_MIN: begin
            if (tidx_ff == T_LAST)
               state_in = (mn_found_ff || rb_cand) ? ST_RB_SUB : ST_AR_SHR;
         end
         ST_RB_SUB: begin
            if (tidx_ff == T_LAST) state_in = ST_AR_SHR;
         end
         ST_AR_SHR: begin
            emit = 1'b1;
            rsp_in.kind       = KIND_ACCEPT;
            rsp_in.request_id = id_ff;
            rsp_in.tenant     = ten_ff;
            if (out_free) state_in = ST_IDLE;
         end
         ST_DS_SCAN: begin
            if (sidx_ff == S_LAST) state_in = ST_DS_PICK;
         end
         ST_DS_PICK: begin
            priority if (r_due) begin
               state_in = ST_DS_DONE;
            end else if (pfound_ff) begin
               state_in = ST_DS_CRED;
            end else begin
               emit = 1'b1;
               rsp_in.kind = KIND_NONE;
               if (out_free) state_in = ST_IDLE;
            end
         end
         ST_DS_CRED: begin
            if (sidx_ff == S_LAST) state_in = ST_DS_DONE;
         end
         ST_DS_DONE: begin
            emit = 1'b1;
            rsp_in.kind       = KIND_DISP;
            rsp_in.request_id = pick_id_ff;
            rsp_in.tenant     = pick_ten_ff;
            rsp_in.method     = method_ff;
            if (out_free) state_in = ST_IDLE;
         end
         ST_RATE: begin
            emit = 1'b1;
            rsp_in.kind = KIND_RATES;
            if (out_free) state_in = ST_IDLE;
         end
         ST_REPORT: begin
            emit = 1'b1;
            rsp_in.kind          = KIND_REPORT;
            rsp_in.tenant        = TEN_W'(tidx_ff);
            rsp_in.reserve_count = res_cnt_ff[tidx_ff];
            rsp_in.weight_count  = wgt_cnt_ff[tidx_ff];
            rsp_in.last          = (tidx_ff == R_LAST);
            if (out_free && tidx_ff == R_LAST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // control, tenant state, counts, valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         res_step_ff  <= RES_STEP_RST;
         lim_step_ff  <= LIM_STEP_RST;
         credit_ff    <= CREDIT_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TENANTS; i++) begin
            ten_rtag_ff[i]  <= '0;
            ten_ltag_ff[i]  <= '0;
            ten_stag_ff[i]  <= '0;
            ten_rrate_ff[i] <= '0;
            ten_lrate_ff[i] <= '0;
            res_cnt_ff[i]   <= '0;
            wgt_cnt_ff[i]   <= '0;
         end
         for (int i = 0; i < PENDING_DEPTH; i++) slot_valid_ff[i] <= 1'b0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RES_STEP: res_step_ff <= csr_wdata;
               CSR_LIM_STEP: lim_step_ff <= csr_wdata;
               CSR_CREDIT:   credit_ff   <= csr_wdata[CREDIT_W-1:0];
               default: ;
            endcase
         end

         // hold or drop the result beat
         if (emit && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)  rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_AR_RES: ten_rtag_ff[rd_t] <= tr.sum_max;
            ST_AR_LIM: ten_ltag_ff[rd_t] <= tr.sum_max;
            ST_RB_SUB: begin
               if (ten_stag_ff[rd_t] != '0) ten_stag_ff[rd_t] <= tr.diff_floor;
            end
            ST_AR_SHR: begin
               if (out_free) begin
                  ten_stag_ff[rd_t]      <= tr.sum_max;
                  slot_valid_ff[free_ff] <= 1'b1;
               end
            end
            ST_DS_PICK: begin
               priority if (r_due)  slot_valid_ff[rsel_ff] <= 1'b0;
               else if (pfound_ff)  slot_valid_ff[psel_ff] <= 1'b0;
               else ;
            end
            ST_DS_DONE: begin
               if (out_free) begin
                  if (method_ff) begin
                     if (wgt_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] != CNT_MAX)
                        wgt_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] <=
                           wgt_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] + 1'b1;
                  end else begin
                     if (res_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] != CNT_MAX)
                        res_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] <=
                           res_cnt_ff[TW'(req_ten_ext(pick_ten_ff))] + 1'b1;
                  end
               end
            end
            ST_RATE: begin
               if (out_free && t_ok) begin
                  ten_rrate_ff[t_idx] <= rho_ff;
                  ten_lrate_ff[t_idx] <= delta_ff;
               end
            end
            ST_REPORT: begin
               if (out_free) begin
                  res_cnt_ff[tidx_ff] <= '0;
                  wgt_cnt_ff[tidx_ff] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // payload: latched item, scan state, slot contents, result beat
   always_ff @(posedge clock) begin
      if (emit && out_free) rsp_ff <= rsp_in;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ten_ff   <= req_tdata[2:0];
               id_ff    <= req_tdata[18:3];
               now_ff   <= req_tdata[58:19];
               rho_ff   <= req_tdata[74:59];
               delta_ff <= req_tdata[90:75];
            end
            sidx_ff   <= '0;
            tidx_ff   <= '0;
            rfound_ff <= 1'b0;
            pfound_ff <= 1'b0;
         end
         ST_AR_CHK: begin
            free_ff <= free_idx;
            mul_ff  <= res_step_ff * ten_rrate_ff[t_idx];
         end
         ST_AR_RES: mul_ff <= lim_step_ff * ten_lrate_ff[t_idx];
         ST_AR_LIM: begin
            tidx_ff     <= '0;
            mn_found_ff <= 1'b0;
         end
         ST_RB_MIN: begin
            if (rb_cand) begin
               mn_ff       <= ten_stag_ff[rd_t];
               mn_found_ff <= 1'b1;
            end
            tidx_ff <= (tidx_ff == T_LAST) ? '0 : tidx_ff + 1'b1;
         end
         ST_RB_SUB: tidx_ff <= (tidx_ff == T_LAST) ? '0 : tidx_ff + 1'b1;
         ST_AR_SHR: begin
            if (out_free) begin
               slot_ten_ff[free_ff]  <= ten_ff;
               slot_id_ff[free_ff]   <= id_ff;
               slot_rtag_ff[free_ff] <= ten_rtag_ff[rd_t];
               slot_ltag_ff[free_ff] <= ten_ltag_ff[rd_t];
               slot_stag_ff[free_ff] <= tr.sum_max;
            end
         end
         ST_DS_SCAN: begin
            if (slot_valid_ff[sidx_ff]) begin
               if (!rfound_ff || slot_rtag_ff[sidx_ff] < rbest_ff) begin
                  rfound_ff   <= 1'b1;
                  rbest_ff    <= slot_rtag_ff[sidx_ff];
                  rsel_ff     <= sidx_ff;
                  rsel_ten_ff <= slot_ten_ff[sidx_ff];
                  rsel_id_ff  <= slot_id_ff[sidx_ff];
               end
               if (slot_ltag_ff[sidx_ff] <= now_tag &&
                   (!pfound_ff || slot_stag_ff[sidx_ff] < pbest_ff)) begin
                  pfound_ff   <= 1'b1;
                  pbest_ff    <= slot_stag_ff[sidx_ff];
                  psel_ff     <= sidx_ff;
                  psel_ten_ff <= slot_ten_ff[sidx_ff];
                  psel_id_ff  <= slot_id_ff[sidx_ff];
               end
            end
            sidx_ff <= (sidx_ff == S_LAST) ? '0 : sidx_ff + 1'b1;
         end
         ST_DS_PICK: begin
            if (r_due) begin
               pick_ten_ff <= rsel_ten_ff;
               pick_id_ff  <= rsel_id_ff;
               method_ff   <= 1'b0;
            end else begin
               pick_ten_ff <= psel_ten_ff;
               pick_id_ff  <= psel_id_ff;
               method_ff   <= 1'b1;
            end
            sidx_ff <= '0;
         end
         ST_DS_CRED: begin
            // take the credit from the tenant's other pending slots
            if (slot_valid_ff[sidx_ff] && slot_ten_ff[sidx_ff] == pick_ten_ff)
               slot_rtag_ff[sidx_ff] <= tr.diff_floor;
            sidx_ff <= (sidx_ff == S_LAST) ? '0 : sidx_ff + 1'b1;
         end
         ST_REPORT: begin
            if (out_free) tidx_ff <= (tidx_ff == R_LAST) ? '0 : tidx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0, rsp_ff.weight_count, rsp_ff.reserve_count,
                        rsp_ff.method, rsp_ff.tenant, rsp_ff.request_id};

endmodule

@@ test/tb_mclock_tag_scheduler_top.sv @@
`timescale 1ns / 100ps

module tb_mclock_tag_scheduler_top;
   import msched_pkg::*;

   localparam int NT         = 8;
   localparam int NSLOT      = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 80;

   typedef struct {
      logic [2:0]       kind;
      logic [ID_W-1:0]  id;
      logic [TEN_W-1:0] tenant;
      logic             method;
      logic [CNT_W-1:0] rcount;
      logic [CNT_W-1:0] wcount;
      logic             last;
   } sched_rsp_type;

   // Scheduler shadow: tag state, pending table and expected responses
   class sched_scoreboard;
      logic [STEP_W-1:0]   res_step;
      logic [STEP_W-1:0]   lim_step;
      logic [CREDIT_W-1:0] credit;
      logic [TAG_W-1:0]    r_tag[NT], l_tag[NT], s_tag[NT];
      logic [RATE_W-1:0]   r_rate[NT], l_rate[NT];
      logic [CNT_W-1:0]    counts[2*NT];
      logic [TAG_W-1:0]    sl_r[NSLOT], sl_l[NSLOT], sl_s[NSLOT];
      bit                  sl_valid[NSLOT];
      logic [TEN_W-1:0]    sl_ten[NSLOT];
      logic [ID_W-1:0]     sl_id[NSLOT];
      sched_rsp_type       expected_rsp[$];
      int                  errors;

      function new();
         res_step = RES_STEP_RST;
         lim_step = LIM_STEP_RST;
         credit   = CREDIT_RST;
         errors   = 0;
         for (int i = 0; i < NT; i++) begin
            r_tag[i] = '0; l_tag[i] = '0; s_tag[i] = '0;
            r_rate[i] = '0; l_rate[i] = '0;
            counts[2*i] = '0; counts[2*i+1] = '0;
         end
         for (int i = 0; i < NSLOT; i++) sl_valid[i] = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [19:0] val);
         case (idx)
            CSR_RES_STEP: res_step = val;
            CSR_LIM_STEP: lim_step = val;
            CSR_CREDIT:   credit   = val[CREDIT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TAG_W-1:0] sat_add(logic [TAG_W-1:0] a, logic [TAG_W-1:0] b);
         logic [TAG_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[TAG_W] ? TAG_MAX : s[TAG_W-1:0];
      endfunction

      function logic [TAG_W-1:0] advance(logic [TAG_W-1:0] tag, logic [STEP_W-1:0] step,
                                          logic [RATE_W-1:0] rate, logic [TAG_W-1:0] now);
         logic [PROD_W-1:0] prod;
         logic [TAG_W-1:0]  t;
         prod = PROD_W'(step) * PROD_W'(rate);
         t = sat_add(tag, TAG_W'(prod >> RATE_FRAC));
         return (t > now) ? t : now;
      endfunction

      function void push(logic [2:0] k, logic [ID_W-1:0] id, logic [TEN_W-1:0] t,
                         logic m, logic [CNT_W-1:0] rc, logic [CNT_W-1:0] wc, logic l);
         sched_rsp_type r;
         r.kind = k; r.id = id; r.tenant = t; r.method = m;
         r.rcount = rc; r.wcount = wc; r.last = l;
         expected_rsp.push_back(r);
      endfunction

      function void arrive(logic [TEN_W-1:0] t, logic [ID_W-1:0] id, logic [TAG_W-1:0] now);
         int free_slot;
         bit found;
         logic [TAG_W-1:0] mn, base;
         free_slot = -1;
         for (int i = NSLOT - 1; i >= 0; i--) if (!sl_valid[i]) free_slot = i;
         if (free_slot < 0) begin
            push(KIND_REJECT, id, t, 0, 0, 0, 1);
            return;
         end
         r_tag[t] = advance(r_tag[t], res_step, r_rate[t], now);
         l_tag[t] = advance(l_tag[t], lim_step, l_rate[t], now);
         // rebase share tags when this tenant's tag is at or below REBASE_LIMIT
         if (s_tag[t] <= REBASE_LIMIT) begin
            found = 0;
            mn = '0;
            for (int i = 0; i < NT; i++)
               if (s_tag[i] != 0 && (!found || s_tag[i] < mn)) begin
                  mn = s_tag[i];
                  found = 1;
               end
            if (found) begin
               base = mn & ~TAG_W'(255);
               for (int i = 0; i < NT; i++) if (s_tag[i] != 0) s_tag[i] -= base;
            end
         end
         s_tag[t] = sat_add(s_tag[t], ONE_MS);
         if (now > s_tag[t]) s_tag[t] = now;
         sl_valid[free_slot] = 1;
         sl_ten[free_slot] = t;
         sl_id[free_slot] = id;
         sl_r[free_slot] = r_tag[t];
         sl_l[free_slot] = l_tag[t];
         sl_s[free_slot] = s_tag[t];
         push(KIND_ACCEPT, id, t, 0, 0, 0, 1);
      endfunction

      function void dispatch(logic [TAG_W-1:0] now);
         int rsel, psel, pick, idx;
         logic m;
         rsel = -1;
         psel = -1;
         for (int i = 0; i < NSLOT; i++) begin
            if (sl_valid[i]) begin
               if (rsel < 0 || sl_r[i] < sl_r[rsel]) rsel = i;
               if (sl_l[i] <= now && (psel < 0 || sl_s[i] < sl_s[psel])) psel = i;
            end
         end
         if (rsel >= 0 && sl_r[rsel] <= now) begin
            pick = rsel; m = 0;
         end else if (psel >= 0) begin
            pick = psel; m = 1;
         end else begin
            push(KIND_NONE, 0, 0, 0, 0, 0, 1);
            return;
         end
         sl_valid[pick] = 0;
         // weight dispatch hands reservation credit back to the same tenant
         if (m)
            for (int i = 0; i < NSLOT; i++)
               if (sl_valid[i] && sl_ten[i] == sl_ten[pick])
                  sl_r[i] = (sl_r[i] > TAG_W'(credit)) ? sl_r[i] - TAG_W'(credit) : '0;
         idx = 2 * sl_ten[pick] + m;
         if (counts[idx] != CNT_MAX) counts[idx]++;
         push(KIND_DISP, sl_id[pick], sl_ten[pick], m, 0, 0, 1);
      endfunction

      function void note_input(logic [1:0] cmd, logic [95:0] d);
         logic [TEN_W-1:0] t;
         logic [TAG_W-1:0] now;
         t = d[2:0];
         now = {d[58:19], 8'h00};
         case (cmd)
            CMD_ARRIVE:   arrive(t, d[18:3], now);
            CMD_DISPATCH: dispatch(now);
            CMD_RATES: begin
               r_rate[t] = d[74:59];
               l_rate[t] = d[90:75];
               push(KIND_RATES, 0, 0, 0, 0, 0, 1);
            end
            default: begin
               for (int k = 0; k < MAX_ROWS; k++) begin
                  push(KIND_REPORT, 0, TEN_W'(k), 0, counts[2*k], counts[2*k+1],
                       k == MAX_ROWS - 1);
                  counts[2*k] = '0;
                  counts[2*k+1] = '0;
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 30) $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_result(logic [2:0] kind, logic [55:0] d, logic l);
         sched_rsp_type e;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d", kind));
            return;
         end
         e = expected_rsp.pop_front();
         if (kind !== e.kind || d[15:0] !== e.id || d[18:16] !== e.tenant ||
             d[19] !== e.method || d[35:20] !== e.rcount || d[51:36] !== e.wcount ||
             d[55:52] !== 4'h0 || l !== e.last)
            report_mismatch($sformatf(
               {"got k%0d id%0h t%0d m%0d rc%0d wc%0d l%0d, ",
                "want k%0d id%0h t%0d m%0d rc%0d wc%0d l%0d"},
               kind, d[15:0], d[18:16], d[19], d[35:20], d[51:36], l,
               e.kind, e.id, e.tenant, e.method, e.rcount, e.wcount, e.last));
      endtask
   endclass

   logic        clock, reset;
   logic [1:0]  req_tuser;
   logic [95:0] req_tdata;
   logic        req_tvalid, req_tready;
   logic [2:0]  rsp_tuser;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast, rsp_tvalid, rsp_tready;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   sched_scoreboard sb = new();
   bit          calm;
   int          rsp_stall;
   int          rsp_draw;
   int          idle_cycles;
   logic [39:0] clock_ms;

   mclock_tag_scheduler_top u_dut (
      .clock(clock), .reset(reset),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // note accepted beats, check results, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side: random stall after each beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw   = calm ? 0 : $urandom_range(0, 3);
         rsp_stall  <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
         rsp_tready <= (rsp_draw == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task send(logic [1:0] cmd, logic [2:0] t, logic [15:0] id, logic [39:0] now,
             logic [15:0] rho, logic [15:0] dlt);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, dlt, rho, now, id, t};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every expected result is back and the block is quiet
   task drain;
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_regs(logic [19:0] rs, logic [19:0] ls, logic [15:0] cr);
      logic [19:0] v[3];
      v[0] = rs; v[1] = ls; v[2] = {4'b0, cr};
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_reg(2'(i), v[i]);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task random_item;
      int sel;
      logic [39:0] now;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) clock_ms = 40'({$urandom, $urandom});
      else clock_ms = clock_ms + $urandom_range(0, 4);
      now = ($urandom_range(0, 19) == 0) ? 40'({$urandom, $urandom}) : clock_ms;
      if (sel < 45)
         send(CMD_ARRIVE, 3'($urandom), 16'($urandom), now, 16'd0, 16'd0);
      else if (sel < 85)
         send(CMD_DISPATCH, 3'($urandom), 16'($urandom), now, 16'($urandom),
              16'($urandom));
      else if (sel < 93)
         send(CMD_RATES, 3'($urandom), 16'($urandom), now,
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192)));
      else
         send(CMD_REPORT, 3'($urandom), 16'($urandom), now, 16'($urandom),
              16'($urandom));
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      calm        = 1'b0;
      idle_cycles = 0;
      clock_ms    = 40'd10;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rates, empty dispatch, table overflow, extremes, report
      write_regs(RES_STEP_RST, LIM_STEP_RST, CREDIT_RST);
      send(CMD_RATES, 3'd0, 16'h0, 40'd0, 16'd4096, 16'd4096);
      send(CMD_RATES, 3'd1, 16'h0, 40'd0, 16'd0, 16'd0);
      send(CMD_RATES, 3'd7, 16'hFFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send(CMD_DISPATCH, 3'd0, 16'h0, 40'd0, 16'h0, 16'h0);
      for (int i = 0; i < 17; i++)
         send(CMD_ARRIVE, 3'(i), (i == 0) ? 16'h0 : (i == 1) ? 16'hFFFF : 16'(i * 911),
              (i == 5) ? 40'hFF_FFFF_FFFF : 40'(i), 16'h0, 16'h0);
      send(CMD_DISPATCH, 3'd0, 16'h0, 40'd5, 16'h0, 16'h0);
      send(CMD_DISPATCH, 3'd0, 16'h0, 40'hFF_FFFF_FFFF, 16'h0, 16'h0);
      send(CMD_REPORT, 3'd0, 16'h0, 40'd0, 16'h0, 16'h0);

      // random phases, each with its own register setting
      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: write_regs(20'd0, 20'd0, 16'd0);
            1: write_regs(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
            2: write_regs(20'($urandom), 20'($urandom), 16'($urandom));
            default: write_regs(RES_STEP_RST, LIM_STEP_RST, 16'd300);
         endcase
         calm = (p == 2);
         for (int i = 0; i < 58; i++) random_item();
         calm = 1'b0;
      end

      drain();
      if (sb.expected_rsp.size() == 0 && sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
